// File: hdl/mslc_pkg.sv
// ----------------------------------------------------------------------------
// mslc_pkg
// Shared codes, defaults and controller/datapath interface types for the
// MOESI snooping LRU cache.
// ----------------------------------------------------------------------------
package mslc_pkg;

    localparam int DEF_MAX_CORES = 8;
    localparam int DEF_MAX_LINES = 64;
    localparam int ADDR_W        = 32;

    // MOESI line state codes
    localparam logic [2:0] ST_I = 3'd0;
    localparam logic [2:0] ST_S = 3'd1;
    localparam logic [2:0] ST_E = 3'd2;
    localparam logic [2:0] ST_O = 3'd3;
    localparam logic [2:0] ST_M = 3'd4;

    localparam logic [3:0] FROM_MEMORY = 4'd8;

    // request actions
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_STORE = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_CORES  = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_LINES  = 2'd2;

    localparam logic [9:0] WB_SAT = 10'd1023;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_SCAN,
        OP_PEERS,
        OP_OWN,
        OP_FLUSH
    } pass_op_t;

    typedef struct packed {
        logic     start;
        pass_op_t op;
        logic     publish;
    } cmd_t;

    typedef struct packed {
        logic pass_done;
        logic req_flush;
        logic req_ignored;
        logic need_peers;
        logic out_free;
    } status_t;

endpackage

// File: hdl/mslc_ram.sv
// ----------------------------------------------------------------------------
// mslc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mslc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/mslc_ctrl.sv
// ----------------------------------------------------------------------------
// mslc_ctrl
// Sequencer: orders the clearing, scan, snoop, update and flush passes.
// ----------------------------------------------------------------------------
module mslc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  mslc_pkg::status_t st,
    output mslc_pkg::cmd_t    cmd,
    output logic              idle
);
    import mslc_pkg::*;

    typedef enum logic [3:0] {
        S_BOOT, S_CLEAR, S_IDLE, S_DECIDE, S_SCAN, S_CHOOSE,
        S_PEERS, S_UPDATE, S_FLUSH, S_RESULT
    } fsm_t;

    fsm_t state_reg;
    cmd_t cmd_reg;

    assign cmd  = cmd_reg;
    assign idle = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_BOOT;
            cmd_reg   <= '{start: 1'b0, op: OP_CLEAR, publish: 1'b0};
        end else begin
            case (state_reg)
                S_BOOT: begin
                    cmd_reg.start   <= 1'b1;
                    cmd_reg.publish <= 1'b0;
                    cmd_reg.op      <= OP_CLEAR;
                    state_reg       <= S_CLEAR;
                end
                S_CLEAR: begin
                    cmd_reg.start   <= 1'b0;
                    cmd_reg.publish <= 1'b0;
                    if (st.pass_done) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    // the datapath captures the request on the accept edge
                    cmd_reg.start   <= 1'b0;
                    cmd_reg.publish <= 1'b0;
                    if (in_accept) state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    cmd_reg.publish <= 1'b0;
                    if (st.req_ignored) begin
                        cmd_reg.start <= 1'b0;
                        state_reg     <= S_RESULT;
                    end else if (st.req_flush) begin
                        cmd_reg.start <= 1'b1;
                        cmd_reg.op    <= OP_FLUSH;
                        state_reg     <= S_FLUSH;
                    end else begin
                        cmd_reg.start <= 1'b1;
                        cmd_reg.op    <= OP_SCAN;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    cmd_reg.start   <= 1'b0;
                    cmd_reg.publish <= 1'b0;
                    if (st.pass_done) state_reg <= S_CHOOSE;
                end
                S_CHOOSE: begin
                    cmd_reg.start   <= 1'b1;
                    cmd_reg.publish <= 1'b0;
                    if (st.need_peers) begin
                        cmd_reg.op <= OP_PEERS;
                        state_reg  <= S_PEERS;
                    end else begin
                        cmd_reg.op <= OP_OWN;
                        state_reg  <= S_UPDATE;
                    end
                end
                S_PEERS: begin
                    cmd_reg.publish <= 1'b0;
                    if (st.pass_done) begin
                        cmd_reg.start <= 1'b1;
                        cmd_reg.op    <= OP_OWN;
                        state_reg     <= S_UPDATE;
                    end else begin
                        cmd_reg.start <= 1'b0;
                    end
                end
                S_UPDATE, S_FLUSH: begin
                    cmd_reg.start   <= 1'b0;
                    cmd_reg.publish <= 1'b0;
                    if (st.pass_done) state_reg <= S_RESULT;
                end
                S_RESULT: begin
                    cmd_reg.start <= 1'b0;
                    if (st.out_free) begin
                        cmd_reg.publish <= 1'b1;
                        state_reg       <= S_IDLE;
                    end else begin
                        cmd_reg.publish <= 1'b0;
                    end
                end
                default: begin
                    cmd_reg.start   <= 1'b0;
                    cmd_reg.publish <= 1'b0;
                    state_reg       <= S_BOOT;
                end
            endcase
        end
    end
endmodule

// File: hdl/mslc_dpath.sv
// ----------------------------------------------------------------------------
// mslc_dpath
// Datapath: request registers, tag and line-state memories, slot walker,
// per-pass element processing, held counts and result register.
// ----------------------------------------------------------------------------
module mslc_dpath #(
    parameter int MAX_CORES = mslc_pkg::DEF_MAX_CORES,
    parameter int MAX_LINES = mslc_pkg::DEF_MAX_LINES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [3:0]                cores_cfg,
    input  logic [3:0]                offset_cfg,
    input  logic [6:0]                lines_cfg,
    input  logic                      in_accept,
    input  logic [1:0]                in_action,
    input  logic [mslc_pkg::ADDR_W-1:0] in_address,
    input  logic [2:0]                in_core,
    input  mslc_pkg::cmd_t            cmd,
    output mslc_pkg::status_t         st,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [23:0]               m_data
);
    import mslc_pkg::*;

    localparam int CW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int SW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int RW    = SW;
    localparam int HW    = $clog2(MAX_LINES + 1);
    localparam int NW    = $clog2(MAX_CORES + 1);
    localparam int DEPTH = MAX_CORES * MAX_LINES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = 4 + RW;

    // effective configuration
    logic [NW-1:0] n_act;
    logic [HW-1:0] cap_eff;
    logic [3:0]    ob_eff;

    always_comb begin
        if (cores_cfg == 4'd0)                n_act = NW'(1);
        else if (32'(cores_cfg) > MAX_CORES)  n_act = NW'(MAX_CORES);
        else                                  n_act = NW'(cores_cfg);
        if (lines_cfg == 7'd0)                cap_eff = HW'(1);
        else if (32'(lines_cfg) > MAX_LINES)  cap_eff = HW'(MAX_LINES);
        else                                  cap_eff = HW'(lines_cfg);
        if (offset_cfg < 4'd2)                ob_eff = 4'd2;
        else if (offset_cfg > 4'd12)          ob_eff = 4'd12;
        else                                  ob_eff = offset_cfg;
    end

    // request registers
    logic [1:0]        act_reg;
    logic [2:0]        core_reg;
    logic [ADDR_W-1:0] tag_reg;
    logic [CW-1:0]     req_cidx;

    assign req_cidx = CW'(core_reg);

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            act_reg  <= in_action;
            core_reg <= in_core;
            tag_reg  <= in_address >> ob_eff;
        end
    end

    logic is_store;
    assign is_store       = (act_reg == ACT_STORE);
    assign st.req_flush   = (act_reg == ACT_FLUSH);
    assign st.req_ignored = !(act_reg inside {ACT_LOAD, ACT_STORE, ACT_FLUSH}) ||
                            ((act_reg != ACT_FLUSH) && (32'(core_reg) >= 32'(n_act)));

    // slot walker; scan and update cover the requesting core only
    pass_op_t      op_reg;
    logic          walk_reg;
    logic [AW-1:0] addr_reg;
    logic [SW-1:0] slot_reg;
    logic [CW-1:0] wcore_reg;
    logic          rd_v_reg;
    logic [AW-1:0] addr_d_reg;
    logic [SW-1:0] slot_d_reg;
    logic [CW-1:0] core_d_reg;
    logic          last_d_reg;
    logic [CW-1:0] last_core;
    logic          walk_last;

    assign last_core = (op_reg == OP_CLEAR) ? CW'(MAX_CORES - 1) : CW'(n_act - NW'(1));
    assign walk_last = (32'(slot_reg) == MAX_LINES - 1) &&
                       ((op_reg inside {OP_OWN, OP_SCAN}) || (wcore_reg == last_core));
    assign st.pass_done = rd_v_reg && last_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg <= 1'b0;
            rd_v_reg <= 1'b0;
            op_reg   <= OP_CLEAR;
        end else begin
            rd_v_reg <= walk_reg;
            if (cmd.start) begin
                walk_reg <= 1'b1;
                op_reg   <= cmd.op;
                slot_reg <= '0;
                if (cmd.op inside {OP_OWN, OP_SCAN}) begin
                    wcore_reg <= req_cidx;
                    addr_reg  <= AW'(32'(req_cidx) * MAX_LINES);
                end else begin
                    wcore_reg <= '0;
                    addr_reg  <= '0;
                end
            end else if (walk_reg) begin
                addr_d_reg <= addr_reg;
                slot_d_reg <= slot_reg;
                core_d_reg <= wcore_reg;
                last_d_reg <= walk_last;
                if (walk_last) begin
                    walk_reg <= 1'b0;
                end else begin
                    addr_reg <= addr_reg + AW'(1);
                    if (32'(slot_reg) == MAX_LINES - 1) begin
                        slot_reg  <= '0;
                        wcore_reg <= wcore_reg + CW'(1);
                    end else begin
                        slot_reg <= slot_reg + SW'(1);
                    end
                end
            end
        end
    end

    // memories
    logic              meta_we;
    logic [MW-1:0]     meta_wd;
    logic [MW-1:0]     meta_rd;
    logic              tag_we;
    logic [ADDR_W-1:0] tag_rd;

    mslc_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (addr_d_reg),
        .wdata (meta_wd),
        .raddr (addr_reg),
        .rdata (meta_rd)
    );

    mslc_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (addr_d_reg),
        .wdata (tag_reg),
        .raddr (addr_reg),
        .rdata (tag_rd)
    );

    logic          rd_occ;
    logic [2:0]    rd_state;
    logic [RW-1:0] rd_rank;
    logic          rd_match;
    logic          rd_mo;

    assign rd_occ   = meta_rd[MW-1];
    assign rd_state = meta_rd[MW-2 -: 3];
    assign rd_rank  = meta_rd[RW-1:0];
    assign rd_match = rd_occ && (tag_rd == tag_reg);
    assign rd_mo    = (rd_state == ST_M) || (rd_state == ST_O);

    // scan results
    logic          f_found_reg, lru_found_reg, free_found_reg;
    logic [SW-1:0] f_slot_reg, lru_slot_reg, free_slot_reg;
    logic [2:0]    f_state_reg, lru_state_reg;
    logic [RW-1:0] f_rank_reg, lru_rank_reg;
    logic [3:0]    src_reg;
    logic [9:0]    wb_reg;
    logic          ev_reg;
    logic [HW-1:0] held_reg [MAX_CORES];

    logic          hit;
    logic          alloc;
    logic          evict;
    logic [SW-1:0] k_slot;
    logic [2:0]    nst;
    logic          peer_el;

    assign hit   = f_found_reg && (f_state_reg != ST_I);
    assign alloc = !f_found_reg;
    assign evict = alloc && lru_found_reg && (held_reg[req_cidx] >= cap_eff);
    assign k_slot = (alloc && evict && (!free_found_reg || (lru_slot_reg < free_slot_reg))) ?
                    lru_slot_reg : (alloc ? free_slot_reg : f_slot_reg);
    assign st.need_peers = !hit || (is_store && ((f_state_reg == ST_S) ||
                                                 (f_state_reg == ST_O)));
    assign peer_el = rd_match && (32'(core_d_reg) != 32'(core_reg));

    always_comb begin
        if (is_store)  nst = ST_M;
        else if (hit)  nst = f_state_reg;
        else           nst = (src_reg == FROM_MEMORY) ? ST_E : ST_S;
    end

    // write-back of the element read in the previous cycle
    always_comb begin
        meta_we = 1'b0;
        meta_wd = meta_rd;
        tag_we  = 1'b0;
        if (rd_v_reg) begin
            case (op_reg)
                OP_CLEAR, OP_FLUSH: begin
                    meta_we = 1'b1;
                    meta_wd = '0;
                end
                OP_PEERS: begin
                    if (peer_el) begin
                        meta_we = 1'b1;
                        if (is_store)          meta_wd[MW-2 -: 3] = ST_I;
                        else if (rd_mo)        meta_wd[MW-2 -: 3] = ST_O;
                        else if (rd_state != ST_I) meta_wd[MW-2 -: 3] = ST_S;
                    end
                end
                OP_OWN: begin
                    if (slot_d_reg == k_slot) begin
                        meta_we = 1'b1;
                        meta_wd = {1'b1, nst, RW'(0)};
                        tag_we  = alloc;
                    end else if (evict && (slot_d_reg == lru_slot_reg)) begin
                        meta_we = 1'b1;
                        meta_wd = '0;
                    end else if (rd_occ && (alloc || (rd_rank < f_rank_reg))) begin
                        meta_we = 1'b1;
                        meta_wd[RW-1:0] = rd_rank + RW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // scan capture and per-request accumulators
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            f_found_reg    <= 1'b0;
            lru_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            src_reg        <= FROM_MEMORY;
            wb_reg         <= '0;
            ev_reg         <= 1'b0;
        end else if (rd_v_reg) begin
            case (op_reg)
                OP_SCAN: begin
                    if (rd_match && !f_found_reg) begin
                        f_found_reg <= 1'b1;
                        f_slot_reg  <= slot_d_reg;
                        f_state_reg <= rd_state;
                        f_rank_reg  <= rd_rank;
                    end
                    if (rd_occ && (!lru_found_reg || (rd_rank > lru_rank_reg))) begin
                        lru_found_reg <= 1'b1;
                        lru_slot_reg  <= slot_d_reg;
                        lru_state_reg <= rd_state;
                        lru_rank_reg  <= rd_rank;
                    end
                    if (!rd_occ && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= slot_d_reg;
                    end
                end
                OP_PEERS: begin
                    if (peer_el) begin
                        if (rd_mo) begin
                            src_reg <= 4'(core_d_reg);
                        end else if ((rd_state == ST_E || rd_state == ST_S) &&
                                     (src_reg == FROM_MEMORY)) begin
                            src_reg <= 4'(core_d_reg);
                        end
                    end
                end
                OP_FLUSH: begin
                    if (rd_occ && rd_mo && (wb_reg != WB_SAT)) wb_reg <= wb_reg + 10'd1;
                end
                OP_OWN: begin
                    if (last_d_reg) begin
                        ev_reg <= evict;
                        wb_reg <= {9'd0, evict && ((lru_state_reg == ST_M) ||
                                                   (lru_state_reg == ST_O))};
                    end
                end
                default: ;
            endcase
        end
    end

    // held counts per core
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < MAX_CORES; j++) held_reg[j] <= '0;
        end else if (st.pass_done) begin
            if (op_reg == OP_OWN && alloc && !evict) begin
                held_reg[req_cidx] <= held_reg[req_cidx] + HW'(1);
            end else if (op_reg == OP_FLUSH) begin
                for (int j = 0; j < MAX_CORES; j++) begin
                    if (j < 32'(n_act)) held_reg[j] <= '0;
                end
            end
        end
    end

    // result register
    logic [23:0] res;
    logic [1:0]  bc;

    always_comb begin
        if (hit) bc = st.need_peers ? 2'd1 : 2'd0;
        else     bc = is_store ? 2'd2 : 2'd1;
        res = '0;
        if (st.req_ignored) begin
            res = '0;
        end else if (st.req_flush) begin
            res[18:9] = wb_reg;
        end else begin
            res[0]     = hit;
            res[4:1]   = hit ? 4'd0 : src_reg;
            res[7:5]   = nst;
            res[8]     = ev_reg;
            res[18:9]  = wb_reg;
            res[20:19] = bc;
        end
    end

    assign st.out_free = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.publish) begin
            m_valid <= 1'b1;
            m_data  <= res;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end
endmodule

// File: hdl/moesi_snoop_lru_cache.sv
// ----------------------------------------------------------------------------
// moesi_snoop_lru_cache
// A load or store runs an own scan, a peer snoop walk over all active cores
// and an own update walk; a hit needing no peers skips the snoop walk. A flush
// walks the lines of all active cores once; an ignored request runs no walk.
// One transaction is in flight at a time; the one-slot memory port walk sets it.
// Reset: synchronous, active low; a clearing pass over all MAX_CORES*MAX_LINES
// slots follows, during which no transaction is accepted.
// ----------------------------------------------------------------------------
module moesi_snoop_lru_cache #(
    parameter int MAX_CORES = mslc_pkg::DEF_MAX_CORES,
    parameter int MAX_LINES = mslc_pkg::DEF_MAX_LINES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[31:0], core[34:32], zero fill
    input  logic [1:0]  s_tuser,   // action[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // hit[0], fill_source[4:1], new_state[7:5],
                                   // evicted[8], writeback_count[18:9],
                                   // broadcast_count[20:19], zero fill
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mslc_pkg::*;

    logic [3:0] cores_reg;
    logic [3:0] offset_reg;
    logic [6:0] lines_reg;
    logic [1:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cores_reg  <= 4'd4;
            offset_reg <= 4'd5;
            lines_reg  <= 7'd64;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CORES:  cores_reg  <= pwdata[3:0];
                REG_OFFSET: offset_reg <= pwdata[3:0];
                REG_LINES:  lines_reg  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CORES:  prdata = {28'd0, cores_reg};
            REG_OFFSET: prdata = {28'd0, offset_reg};
            REG_LINES:  prdata = {25'd0, lines_reg};
            default:    prdata = '0;
        endcase
    end

    cmd_t    cmd;
    status_t st;
    logic    idle;
    logic    in_accept;

    // take a request only while the sequencer rests
    assign s_tready  = idle;
    assign in_accept = s_tvalid && s_tready;

    // sequencer: steps through the passes of one transaction
    mslc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .st        (st),
        .cmd       (cmd),
        .idle      (idle)
    );

    // datapath: tag stores, walker and result register
    mslc_dpath #(.MAX_CORES(MAX_CORES), .MAX_LINES(MAX_LINES)) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cores_cfg  (cores_reg),
        .offset_cfg (offset_reg),
        .lines_cfg  (lines_reg),
        .in_accept  (in_accept),
        .in_action  (s_tuser),
        .in_address (s_tdata[31:0]),
        .in_core    (s_tdata[34:32]),
        .cmd        (cmd),
        .st         (st),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (m_tdata)
    );

endmodule

// File: tb/sv/mslc_scoreboard.sv
// ----------------------------------------------------------------------------
// mslc_scoreboard
// Watches the request, result and register channels of the MOESI snooping
// LRU cache, keeps its own copy of every tag store, predicts each result and
// compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module mslc_scoreboard
    import mslc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    localparam int NC = DEF_MAX_CORES;
    localparam int NL = DEF_MAX_LINES;

    // lowest field last, so hit lands in bit 0
    typedef struct packed {
        logic [1:0] bc;
        logic [9:0] wb;
        logic       ev;
        logic [2:0] nst;
        logic [3:0] src;
        logic       hit;
    } outcome_t;

    logic [3:0]  cfg_cores;
    logic [3:0]  cfg_offset;
    logic [6:0]  cfg_lines;

    logic [31:0] ln_tag  [NC*NL];
    logic [2:0]  ln_st   [NC*NL];
    bit          ln_occ  [NC*NL];
    int          ln_rank [NC*NL];
    int          held    [NC];
    int          acc_ev;
    int          acc_wb;

    outcome_t    expected_q [$];

    function automatic int active_cores();
        if (cfg_cores == 0) return 1;
        if (cfg_cores > NC) return NC;
        return int'(cfg_cores);
    endfunction

    function automatic int line_cap();
        if (cfg_lines == 0) return 1;
        if (cfg_lines > NL) return NL;
        return int'(cfg_lines);
    endfunction

    function automatic int offset_bits();
        if (cfg_offset < 2) return 2;
        if (cfg_offset > 12) return 12;
        return int'(cfg_offset);
    endfunction

    function automatic int lookup(int c, logic [31:0] tag);
        for (int s = 0; s < NL; s++)
            if (ln_occ[c*NL+s] && ln_tag[c*NL+s] == tag) return c*NL + s;
        return -1;
    endfunction

    function automatic void touch(int c, int k);
        int r;
        r = ln_rank[k];
        for (int s = 0; s < NL; s++)
            if (ln_occ[c*NL+s] && ln_rank[c*NL+s] < r) ln_rank[c*NL+s]++;
        ln_rank[k] = 0;
    endfunction

    // drop the LRU line of core c, return 1 when it was dirty
    function automatic int drop_lru(int c);
        int best;
        bit found;
        int wb;
        best = 0;
        found = 0;
        for (int s = 0; s < NL; s++) begin
            if (ln_occ[c*NL+s] && (!found || ln_rank[c*NL+s] > ln_rank[best])) begin
                best = c*NL + s;
                found = 1;
            end
        end
        if (!found) return 0;
        wb = (ln_st[best] == ST_M || ln_st[best] == ST_O) ? 1 : 0;
        ln_occ[best] = 0;
        ln_st[best] = ST_I;
        ln_rank[best] = 0;
        if (held[c] > 0) held[c]--;
        return wb;
    endfunction

    function automatic int first_free(int c, int dflt);
        for (int s = 0; s < NL; s++)
            if (!ln_occ[c*NL+s]) return c*NL + s;
        return dflt;
    endfunction

    function automatic int place_line(int c, logic [31:0] tag);
        int k;
        if (held[c] >= line_cap()) begin
            acc_wb += drop_lru(c);
            acc_ev = 1;
        end
        k = first_free(c, c*NL);
        if (ln_occ[k]) begin
            acc_wb += drop_lru(c);
            acc_ev = 1;
            k = first_free(c, k);
        end
        for (int s = 0; s < NL; s++)
            if (ln_occ[c*NL+s]) ln_rank[c*NL+s]++;
        ln_occ[k] = 1;
        ln_tag[k] = tag;
        ln_st[k] = ST_I;
        ln_rank[k] = 0;
        held[c]++;
        return k;
    endfunction

    function automatic logic [3:0] snoop_peers(int c, logic [31:0] tag, bit wr);
        logic [3:0] src;
        int f;
        src = FROM_MEMORY;
        for (int j = 0; j < active_cores(); j++) begin
            if (j == c) continue;
            f = lookup(j, tag);
            if (f < 0) continue;
            case (ln_st[f])
                ST_M, ST_O: begin
                    src = 4'(j);
                    if (!wr) ln_st[f] = ST_O;
                end
                ST_E, ST_S: begin
                    if (src == FROM_MEMORY) src = 4'(j);
                    if (!wr) ln_st[f] = ST_S;
                end
                default: ;
            endcase
            if (wr) ln_st[f] = ST_I;
        end
        return src;
    endfunction

    function automatic void kill_peers(int c, logic [31:0] tag);
        int f;
        for (int j = 0; j < active_cores(); j++) begin
            if (j == c) continue;
            f = lookup(j, tag);
            if (f >= 0) ln_st[f] = ST_I;
        end
    endfunction

    function automatic outcome_t coherence_access(logic [1:0] act, logic [31:0] addr,
                                                  int c);
        outcome_t r;
        logic [31:0] tag;
        int f;
        int k;
        r = '0;
        acc_ev = 0;
        acc_wb = 0;
        tag = addr >> offset_bits();
        if (act == ACT_FLUSH) begin
            for (int j = 0; j < active_cores(); j++)
                while (held[j] > 0) acc_wb += drop_lru(j);
        end else if ((act == ACT_LOAD || act == ACT_STORE) && c < active_cores()) begin
            f = lookup(c, tag);
            if (f >= 0 && ln_st[f] != ST_I) begin
                r.hit = 1'b1;
                touch(c, f);
                if (act == ACT_STORE) begin
                    if (ln_st[f] == ST_S || ln_st[f] == ST_O) begin
                        kill_peers(c, tag);
                        r.bc = 2'd1;
                    end
                    ln_st[f] = ST_M;
                end
                r.nst = ln_st[f];
            end else begin
                r.src = snoop_peers(c, tag, act == ACT_STORE);
                r.bc = 2'd1;
                if (act == ACT_STORE) begin
                    kill_peers(c, tag);
                    r.bc = 2'd2;
                end
                if (f >= 0) begin
                    k = f;
                    touch(c, k);
                end else begin
                    k = place_line(c, tag);
                end
                if (act == ACT_STORE) ln_st[k] = ST_M;
                else ln_st[k] = (r.src == FROM_MEMORY) ? ST_E : ST_S;
                r.nst = ln_st[k];
            end
        end
        r.ev = acc_ev[0];
        r.wb = (acc_wb > WB_SAT) ? WB_SAT : acc_wb[9:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        if (!aresetn) begin
            cfg_cores  <= 4'd4;
            cfg_offset <= 4'd5;
            cfg_lines  <= 7'd64;
            for (int i = 0; i < NC*NL; i++) begin
                ln_tag[i]  = '0;
                ln_st[i]   = ST_I;
                ln_occ[i]  = 0;
                ln_rank[i] = 0;
            end
            for (int i = 0; i < NC; i++) held[i] = 0;
            expected_q.delete();
            errors  <= 0;
            pending <= 0;
        end else begin
            // register writes land at the access edge
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_CORES:  cfg_cores  <= pwdata[3:0];
                    REG_OFFSET: cfg_offset <= pwdata[3:0];
                    REG_LINES:  cfg_lines  <= pwdata[6:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(coherence_access(s_tuser, s_tdata[31:0],
                                                      int'(s_tdata[34:32])));
            if (m_tvalid && m_tready) begin
                got = m_tdata[20:0];
                if (expected_q.size() == 0) begin
                    $display("%0t: result %h with nothing expected", $realtime, got);
                    errors <= errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want != got) begin
                        $display("%0t: mismatch expected hit=%0d src=%0d st=%0d ev=%0d wb=%0d bc=%0d",
                                 $realtime, want.hit, want.src, want.nst, want.ev,
                                 want.wb, want.bc);
                        $display("%0t:            actual hit=%0d src=%0d st=%0d ev=%0d wb=%0d bc=%0d",
                                 $realtime, got.hit, got.src, got.nst, got.ev,
                                 got.wb, got.bc);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// File: tb/sv/tb_moesi_snoop_lru_cache.sv
// ----------------------------------------------------------------------------
// tb_moesi_snoop_lru_cache
// Drives loads, stores and flushes into the MOESI snooping cache under a
// series of core count, block size and capacity settings, with random gaps
// on both channels; the scoreboard predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_moesi_snoop_lru_cache;
    import mslc_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int POOL_SIZE = 12;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // address[31:0], core[34:32], zero fill
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // hit[0], fill_source[4:1], new_state[7:5], evicted[8],
                            // writeback_count[18:9], broadcast_count[20:19], zero fill
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          cycles = 0;
    bit          src_quiet;   // no gaps on the request side
    bit          sink_quiet;  // no stalls on the result side
    logic [31:0] addr_pool [POOL_SIZE];

    moesi_snoop_lru_cache u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mslc_scoreboard u_scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog: end the run if the block hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: stall a random number of cycles before each transaction
    initial begin
        int w;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            w = sink_quiet ? 0 : $urandom_range(0, 15);
            if (w > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (w - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // send one request transaction, after a random gap
    task automatic send_request(logic [1:0] act, logic [31:0] addr, logic [2:0] core);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'd0, core, addr};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold until every result is back and the block takes requests again
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(int ncores, int offs, int nlines);
        write_reg(REG_CORES, 32'(ncores));
        write_reg(REG_OFFSET, 32'(offs));
        write_reg(REG_LINES, 32'(nlines));
    endtask

    // random phase: mostly reuse a small address pool so lines are shared,
    // snooped, invalidated and evicted; sprinkle in noise
    task automatic random_phase(int count);
        logic [1:0]  act;
        logic [31:0] addr;
        logic [2:0]  core;
        int          roll;
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom();
        src_quiet  = ($urandom_range(0, 3) == 0);
        sink_quiet = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)       act = ACT_FLUSH;
            else if (roll < 4)  act = ACT_UNUSED;
            else if (roll < 50) act = ACT_LOAD;
            else                act = ACT_STORE;
            if ($urandom_range(0, 99) < 85)
                addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^ $urandom_range(0, 3);
            else
                addr = $urandom();
            core = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(0, 3));
            send_request(act, addr, core);
        end
        drain();
    endtask

    initial begin
        int cfg_table [10][3] = '{
            '{8, 2, 64}, '{1, 12, 1}, '{8, 12, 2}, '{0, 0, 0}, '{15, 15, 127},
            '{2, 5, 3}, '{4, 3, 4}, '{8, 6, 8}, '{3, 2, 1}, '{8, 4, 5}
        };
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_LOAD;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // wait out the clearing pass
        do @(posedge aclk); while (!s_tready);

        // directed: sharing, ownership, invalidation, reuse of an I slot
        send_request(ACT_LOAD,   32'h0000_0000, 3'd0);  // miss, fill E from memory
        send_request(ACT_LOAD,   32'h0000_0004, 3'd1);  // E peer becomes S
        send_request(ACT_STORE,  32'h0000_0008, 3'd2);  // store miss, peers invalidated
        send_request(ACT_LOAD,   32'h0000_0000, 3'd0);  // local I slot reused
        send_request(ACT_LOAD,   32'h0000_0000, 3'd3);  // O/S sharers
        send_request(ACT_STORE,  32'h0000_0000, 3'd3);  // store hit on S
        send_request(ACT_STORE,  32'hFFFF_FFFF, 3'd1);  // top address, store miss
        send_request(ACT_STORE,  32'hFFFF_FFE0, 3'd1);  // store hit on M
        send_request(ACT_LOAD,   32'hFFFF_FFFF, 3'd2);  // M peer becomes O
        send_request(ACT_STORE,  32'hFFFF_FFFF, 3'd1);  // store hit on O
        send_request(ACT_LOAD,   32'h1234_5678, 3'd0);
        send_request(ACT_STORE,  32'h1234_5678, 3'd0);  // silent E to M
        send_request(ACT_UNUSED, 32'hDEAD_BEEF, 3'd0);  // ignored action
        send_request(ACT_LOAD,   32'h0000_0040, 3'd7);  // core not active
        send_request(ACT_FLUSH,  32'hAAAA_5555, 3'd5);  // flush with dirty lines
        drain();

        // capacity of two: evictions, dirty writebacks, I-slot reuse after store
        set_config(4, 2, 2);
        send_request(ACT_STORE, 32'h0000_0010, 3'd0);
        send_request(ACT_LOAD,  32'h0000_0020, 3'd0);
        send_request(ACT_LOAD,  32'h0000_0030, 3'd0);  // evict dirty LRU
        send_request(ACT_STORE, 32'h0000_0020, 3'd1);  // invalidate core 0's copy
        send_request(ACT_STORE, 32'h0000_0020, 3'd0);  // store miss on local I line
        send_request(ACT_LOAD,  32'h0000_0040, 3'd0);
        drain();
        set_config(4, 5, 1);                            // capacity below held count
        send_request(ACT_LOAD,  32'h0000_1000, 3'd0);
        send_request(ACT_FLUSH, 32'h0000_0000, 3'd0);
        drain();

        for (int p = 0; p < 10; p++) begin
            set_config(cfg_table[p][0], cfg_table[p][1], cfg_table[p][2]);
            random_phase(108);
        end

        // let any trailing activity settle, then judge
        repeat (700) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
